// ===== rtl/core/mp2_pkg.sv =====
// ----------------------------------------------------------------------------
// Maximal points package
// Shared defaults, chain commands, controller states and chain status.
// ----------------------------------------------------------------------------
package mp2_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [3:0] {
    CMD_HOLD   = 4'b0001,
    CMD_DELETE = 4'b0010,
    CMD_INSERT = 4'b0100,
    CMD_DRAIN  = 4'b1000
  } cmd_e_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PROC = 3'b010,
    ST_EMIT = 3'b100
  } state_e_t;

  typedef struct packed {
    logic any_dom;
    logic any_cov;
    logic full;
    logic head_valid;
    logic head_last;
  } stat_t;

endpackage

// ===== rtl/core/maximal_points_2d.sv =====
// ----------------------------------------------------------------------------
// Two-dimensional maximal point filter
// Keeps the maximal set of a stream of points in a sorted chain of cells and
// emits it in ascending x after the final point of each set.
// ----------------------------------------------------------------------------
//  channel | direction | tdata          | tlast       | tuser
//  in_     | slave     | point_x,point_y| last_point  | -
//  out_    | master    | out_x,out_y    | last_of_run | overflow
//
// A point is taken in ST_IDLE; ST_PROC removes each kept point it covers,
// then inserts or drops the point; the cells remove covered points one per cycle.
// A final point is followed by one output word per cycle while out_tready is
// high; the cell chain shifts toward the head as each word is taken.
// Input is not accepted while a point is being worked on or a run is emitted.
// Reset empties the chain and clears the overflow flag.
// ----------------------------------------------------------------------------
module maximal_points_2d #(
  parameter int CAPACITY   = mp2_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = mp2_pkg::COORD_BITS_DEF,
  localparam int DATA_W    = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // point_x, point_y
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // out_x, out_y
  output logic              out_tlast,
  output logic              out_tuser   // overflow
);
  import mp2_pkg::*;

  cmd_e_t                       cmd;
  stat_t                        stat;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic [CAPACITY-1:0]          c_valid;
  logic [CAPACITY-1:0]          c_dom;
  logic [CAPACITY-1:0]          c_cov;
  logic [CAPACITY-1:0]          c_gt;
  logic signed [COORD_BITS-1:0] c_x [CAPACITY];
  logic signed [COORD_BITS-1:0] c_y [CAPACITY];

  assign in_x = in_tdata[COORD_BITS-1:0];
  assign in_y = in_tdata[2*COORD_BITS-1:COORD_BITS];

  mp2_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd),
    .px       (px),
    .py       (py),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .overflow (out_tuser)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                         prev_valid;
    logic signed [COORD_BITS-1:0] prev_x;
    logic signed [COORD_BITS-1:0] prev_y;
    logic                         prev_gt;
    logic                         next_valid;
    logic signed [COORD_BITS-1:0] next_x;
    logic signed [COORD_BITS-1:0] next_y;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b0;
      assign prev_x     = '0;
      assign prev_y     = '0;
      assign prev_gt    = 1'b0;
    end else begin : g_body
      assign prev_valid = c_valid[i-1];
      assign prev_x     = c_x[i-1];
      assign prev_y     = c_y[i-1];
      assign prev_gt    = c_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_x     = '0;
      assign next_y     = '0;
    end else begin : g_link
      assign next_valid = c_valid[i+1];
      assign next_x     = c_x[i+1];
      assign next_y     = c_y[i+1];
    end

    mp2_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .px        (px),
      .py        (py),
      .prev_valid(prev_valid),
      .prev_x    (prev_x),
      .prev_y    (prev_y),
      .prev_gt   (prev_gt),
      .next_valid(next_valid),
      .next_x    (next_x),
      .next_y    (next_y),
      .valid     (c_valid[i]),
      .x         (c_x[i]),
      .y         (c_y[i]),
      .dom       (c_dom[i]),
      .cov       (c_cov[i]),
      .gt        (c_gt[i])
    );
  end

  always_comb begin
    stat.any_dom    = |c_dom;
    stat.any_cov    = |c_cov;
    stat.full       = c_valid[CAPACITY-1];
    stat.head_valid = c_valid[0];
    stat.head_last  = !c_valid[1];
  end

  always_comb begin
    out_tdata                          = '0;
    out_tdata[COORD_BITS-1:0]          = c_x[0];
    out_tdata[2*COORD_BITS-1:COORD_BITS] = c_y[0];
  end

  assign out_tlast = !c_valid[1];

endmodule

// ===== rtl/core/mp2_cell.sv =====
// ----------------------------------------------------------------------------
// Maximal points cell
// Holds one kept point and compares it with the point under work.
// ----------------------------------------------------------------------------
module mp2_cell #(
  parameter int COORD_BITS = mp2_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mp2_pkg::cmd_e_t              cmd,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic                         prev_valid,
  input  logic signed [COORD_BITS-1:0] prev_x,
  input  logic signed [COORD_BITS-1:0] prev_y,
  input  logic                         prev_gt,
  input  logic                         next_valid,
  input  logic signed [COORD_BITS-1:0] next_x,
  input  logic signed [COORD_BITS-1:0] next_y,
  output logic                         valid,
  output logic signed [COORD_BITS-1:0] x,
  output logic signed [COORD_BITS-1:0] y,
  output logic                         dom,
  output logic                         cov,
  output logic                         gt
);
  import mp2_pkg::*;

  logic                         valid_r;
  logic                         valid_nxt;
  logic signed [COORD_BITS-1:0] x_r;
  logic signed [COORD_BITS-1:0] x_nxt;
  logic signed [COORD_BITS-1:0] y_r;
  logic signed [COORD_BITS-1:0] y_nxt;
  logic                         keep;

  assign dom  = valid_r && (x_r >= px) && (y_r >= py);
  assign cov  = valid_r && (x_r <= px) && (y_r <= py);
  assign gt   = !valid_r || (x_r > px);
  assign keep = valid_r && (x_r <= px) && (y_r > py);

  always_comb begin
    valid_nxt = valid_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    unique case (cmd)
      CMD_HOLD: begin
      end
      CMD_DELETE: begin
        if (!keep) begin
          valid_nxt = next_valid;
          x_nxt     = next_x;
          y_nxt     = next_y;
        end
      end
      CMD_INSERT: begin
        if (gt) begin
          if (!prev_gt) begin
            valid_nxt = 1'b1;
            x_nxt     = px;
            y_nxt     = py;
          end else begin
            valid_nxt = prev_valid;
            x_nxt     = prev_x;
            y_nxt     = prev_y;
          end
        end
      end
      CMD_DRAIN: begin
        valid_nxt = next_valid;
        x_nxt     = next_x;
        y_nxt     = next_y;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign valid = valid_r;
  assign x     = x_r;
  assign y     = y_r;

endmodule

// ===== rtl/core/mp2_ctrl.sv =====
// ----------------------------------------------------------------------------
// Maximal points controller
// Holds the point under work and sequences removal, insertion and draining.
// ----------------------------------------------------------------------------
module mp2_ctrl #(
  parameter int COORD_BITS = mp2_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic                         in_last,
  output logic                         in_ready,
  input  mp2_pkg::stat_t               stat,
  output mp2_pkg::cmd_e_t              cmd,
  output logic signed [COORD_BITS-1:0] px,
  output logic signed [COORD_BITS-1:0] py,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         overflow
);
  import mp2_pkg::*;

  state_e_t                     state_r;
  state_e_t                     state_nxt;
  logic signed [COORD_BITS-1:0] px_r;
  logic signed [COORD_BITS-1:0] py_r;
  logic                         last_r;
  logic                         ovf_r;
  logic                         ovf_nxt;
  logic                         done;

  always_comb begin
    state_nxt = state_r;
    ovf_nxt   = ovf_r;
    cmd       = CMD_HOLD;
    done      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_PROC;
        end
      end
      ST_PROC: begin
        priority if (stat.any_dom) begin
          done = 1'b1;
        end else if (stat.any_cov) begin
          cmd = CMD_DELETE;
        end else if (stat.full) begin
          ovf_nxt = 1'b1;
          done    = 1'b1;
        end else begin
          cmd  = CMD_INSERT;
          done = 1'b1;
        end
        if (done) begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_ready && stat.head_valid) begin
          cmd = CMD_DRAIN;
          if (stat.head_last) begin
            state_nxt = ST_IDLE;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
    end
    if (state_r == ST_IDLE && in_valid) begin
      px_r   <= in_x;
      py_r   <= in_y;
      last_r <= in_last;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT) && stat.head_valid;
  assign overflow  = ovf_r;
  assign px        = px_r;
  assign py        = py_r;

endmodule
